@@ rtl/tsil_pkg.sv @@
// ----------------------------------------------------------------------------
// tsil_pkg
// Shared types and constants for the two-level sorted index lookup.
// ----------------------------------------------------------------------------
package tsil_pkg;

  localparam int unsigned STORE_BYTES_DEF = 65536;
  localparam int unsigned BYTE_BITS = 8;

  localparam logic [2:0] ST_WRITTEN      = 3'd0;
  localparam logic [2:0] ST_FOUND        = 3'd1;
  localparam logic [2:0] ST_NO_FIRST     = 3'd2;
  localparam logic [2:0] ST_NO_SECOND    = 3'd3;
  localparam logic [2:0] ST_OUT_OF_STORE = 3'd4;

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [2:0] REG_COUNT_BYTES = 3'd1;
  localparam logic [2:0] REG_FKEY_BYTES  = 3'd2;
  localparam logic [2:0] REG_SKEY_BYTES  = 3'd3;
  localparam logic [2:0] REG_FOFF_BYTES  = 3'd4;
  localparam logic [2:0] REG_SOFF_BYTES  = 3'd5;
  localparam logic [2:0] REG_BASE_OFFSET = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [15:0] store_address;
    logic [7:0]  store_byte;
    logic [31:0] first_key;
    logic [31:0] second_key;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [32:0] location;
    logic [15:0] first_index;
    logic [15:0] second_index;
  } out_word_t;

  // Field being gathered byte by byte.
  typedef enum logic [2:0] {
    FLD_COUNT, FLD_KEY1, FLD_OFF1, FLD_KEY2, FLD_OFF2
  } field_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic   store_wr;     // write one store byte
    logic   init_l1;      // start first-level search
    logic   init_l2;      // start second-level search from the hit entry
    logic   probe_start;  // compute probe address from lo/hi
    logic   mul_done;     // form entry start address from the product
    logic   rd_issue;     // issue a store read at the byte pointer
    logic   rd_take;      // shift read byte into the field register
    field_t fld;          // field being assembled
    logic   field_begin;  // load pointer with the field start
    logic   compare1;     // narrow range on first level
    logic   compare2;     // narrow range on second level
  } tsil_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic range_empty;  // lo > hi
    logic addr_bad;     // byte pointer at or past the store
    logic field_last;   // current byte is last of field
    logic key_eq;       // key equals search key
  } tsil_stat_t;

  function automatic logic [2:0] eff_width(input logic [2:0] w);
    if (w == 3'd0) return 3'd1;
    if (w > 3'd4) return 3'd4;
    return w;
  endfunction

endpackage

@@ rtl/two_level_sorted_index_lookup.sv @@
// ----------------------------------------------------------------------------
// A store word gives its result in the cycle after it is taken; a lookup
// forms each probe's entry address, then reads its fields byte by byte from
// the store, with up to 16 probes on the first level and up to 32 on the second.
// Throughput: one word at a time; the next word is taken once the result is.
// Reset: synchronous rst_n restores the configuration defaults; the store
// contents are undefined until written.
// ----------------------------------------------------------------------------
// two_level_sorted_index_lookup
// Binary-search lookup over a packed two-level index in a byte store.
// ----------------------------------------------------------------------------
module two_level_sorted_index_lookup #(
  parameter int unsigned STORE_BYTES = tsil_pkg::STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsil_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tsil_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import tsil_pkg::*;

  tsil_cmd_t   cmd;
  tsil_stat_t  stat;
  logic [2:0]  status;
  logic [32:0] location;
  logic [15:0] idx1, idx2;
  logic        found;

  tsil_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .item_cmd(in_data.cmd),
    .out_valid, .out_ready, .status, .cmd, .stat
  );

  tsil_datapath #(.STORE_BYTES(STORE_BYTES)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .item(in_data), .cmd, .stat,
    .location, .first_index(idx1), .second_index(idx2)
  );

  // Non-found results report zeros.
  assign found = status == ST_FOUND;
  assign out_data.status       = status;
  assign out_data.location     = found ? location : '0;
  assign out_data.first_index  = found ? idx1 : '0;
  assign out_data.second_index = found ? idx2 : '0;

endmodule

@@ rtl/tsil_datapath.sv @@
// ----------------------------------------------------------------------------
// tsil_datapath
// Store memory, configuration registers, search bounds and field assembly.
// ----------------------------------------------------------------------------
module tsil_datapath #(
  parameter int unsigned STORE_BYTES = tsil_pkg::STORE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  tsil_pkg::in_word_t   item,
  input  tsil_pkg::tsil_cmd_t  cmd,
  output tsil_pkg::tsil_stat_t stat,
  output logic [32:0]          location,
  output logic [15:0]          first_index,
  output logic [15:0]          second_index
);
  import tsil_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_data_r;

  // Configuration registers.
  logic [15:0] entry_count_r;
  logic [2:0]  cw_r, k1w_r, k2w_r, o1w_r, o2w_r;
  logic [31:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      cw_r <= 3'd4; k1w_r <= 3'd4; k2w_r <= 3'd4; o1w_r <= 3'd4; o2w_r <= 3'd4;
      base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENTRY_COUNT: entry_count_r <= cfg_data[15:0];
        REG_COUNT_BYTES: cw_r <= cfg_data[2:0];
        REG_FKEY_BYTES:  k1w_r <= cfg_data[2:0];
        REG_SKEY_BYTES:  k2w_r <= cfg_data[2:0];
        REG_FOFF_BYTES:  o1w_r <= cfg_data[2:0];
        REG_SOFF_BYTES:  o2w_r <= cfg_data[2:0];
        REG_BASE_OFFSET: base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2:0] cw, k1w, k2w, o1w, o2w;
  assign cw  = eff_width(cw_r);
  assign k1w = eff_width(k1w_r);
  assign k2w = eff_width(k2w_r);
  assign o1w = eff_width(o1w_r);
  assign o2w = eff_width(o2w_r);

  // Search state; 34-bit signed bounds cover 32-bit counts.
  logic signed [33:0] lo_r, hi_r, mid_r;
  logic               level2_r;
  logic [49:0]        prod_r;
  logic [50:0]        base_a_r;  // entry start address
  logic [50:0]        ptr_r;
  logic [2:0]         left_r;
  logic [31:0]        fv_r;
  logic [31:0]        cnt_r, off1_r, key_r;
  logic [31:0]        k1_r, k2_r;  // search keys, held for the whole lookup
  logic [15:0]        idx1_r, idx2_r;
  logic [32:0]        loc_r;

  logic signed [33:0] mid_c;
  assign mid_c = lo_r + ((hi_r - lo_r) >>> 1);

  logic [3:0] e1, e2;
  assign e1 = {1'b0, cw} + {1'b0, k1w} + {1'b0, o1w};
  assign e2 = {1'b0, k2w} + {1'b0, o2w};

  logic [31:0] fv_next;
  assign fv_next = {fv_r[23:0], rd_data_r};

  // Store write address, sized to the memory.
  logic [AW-1:0] wr_addr;
  assign wr_addr = AW'(item.store_address);

  // Field start offset and width within the entry.
  logic [3:0] f_off;
  logic [2:0] f_w;
  always_comb begin
    case (cmd.fld)
      FLD_COUNT: begin f_off = 4'd0; f_w = cw; end
      FLD_KEY1:  begin f_off = {1'b0, cw}; f_w = k1w; end
      FLD_OFF1:  begin f_off = {1'b0, cw} + {1'b0, k1w}; f_w = o1w; end
      FLD_KEY2:  begin f_off = 4'd0; f_w = k2w; end
      FLD_OFF2:  begin f_off = {1'b0, k2w}; f_w = o2w; end
      default:   begin f_off = 4'd0; f_w = 3'd1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr && ({16'd0, item.store_address} < 32'(STORE_BYTES)))
      mem[wr_addr] <= item.store_byte;
    if (cmd.rd_issue)
      rd_data_r <= mem[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.init_l1) begin
      lo_r <= '0;
      hi_r <= $signed({18'd0, entry_count_r}) - 34'sd1;
      level2_r <= 1'b0;
      loc_r <= '0; idx1_r <= '0; idx2_r <= '0;
      k1_r <= item.first_key;
      k2_r <= item.second_key;
    end
    if (cmd.init_l2) begin
      lo_r <= '0;
      hi_r <= $signed({2'b00, cnt_r}) - 34'sd1;
      level2_r <= 1'b1;
    end
    if (cmd.probe_start) begin
      mid_r <= mid_c;
      prod_r <= mid_c[32:0] * (level2_r ? {13'd0, e2} : {13'd0, e1});
    end
    if (cmd.mul_done)
      base_a_r <= level2_r ? {1'b0, prod_r} + {19'd0, off1_r} : {1'b0, prod_r};
    if (cmd.field_begin) begin
      ptr_r <= base_a_r + {47'd0, f_off};
      left_r <= f_w;
      fv_r <= '0;
    end
    if (cmd.rd_take) begin
      fv_r <= fv_next;
      ptr_r <= ptr_r + 51'd1;
      left_r <= left_r - 3'd1;
      if (left_r == 3'd1) begin
        case (cmd.fld)
          FLD_COUNT: cnt_r <= fv_next;
          FLD_OFF1:  off1_r <= fv_next;
          FLD_OFF2:  loc_r <= {1'b0, base_r} + {1'b0, fv_next};
          default:   key_r <= fv_next;
        endcase
      end
    end
    if (cmd.compare1 || cmd.compare2) begin
      if (key_r < (cmd.compare1 ? k1_r : k2_r))
        lo_r <= mid_r + 34'sd1;
      else if (key_r != (cmd.compare1 ? k1_r : k2_r))
        hi_r <= mid_r - 34'sd1;
      else if (cmd.compare1)
        idx1_r <= mid_r[15:0];
      else
        idx2_r <= mid_r[15:0];
    end
  end

  // Status back to the controller.
  assign stat.range_empty = lo_r > hi_r;
  assign stat.addr_bad    = ptr_r >= 51'(STORE_BYTES);
  assign stat.field_last  = left_r == 3'd1;
  assign stat.key_eq      = key_r == (level2_r ? k2_r : k1_r);

  assign location     = loc_r;
  assign first_index  = idx1_r;
  assign second_index = idx2_r;

endmodule

@@ rtl/tsil_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsil_ctrl
// Sequencer for store writes and the two binary searches.
// ----------------------------------------------------------------------------
module tsil_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 item_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output tsil_pkg::tsil_cmd_t  cmd,
  input  tsil_pkg::tsil_stat_t stat
);
  import tsil_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_MUL, S_FSTART, S_RD, S_WAIT, S_TAKE, S_CMP, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  field_t     fld_r, fld_nxt;
  logic       lvl2_r, lvl2_nxt;
  logic [2:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign status    = st_r;

  always_comb begin
    state_nxt = state_r; fld_nxt = fld_r; lvl2_nxt = lvl2_r;
    st_nxt = st_r; ov_nxt = ov_r;
    cmd = '0;
    cmd.fld = fld_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (item_cmd == CMD_STORE) begin
            cmd.store_wr = 1'b1;
            st_nxt = ST_WRITTEN;
            ov_nxt = 1'b1;
          end else begin
            cmd.init_l1 = 1'b1;
            lvl2_nxt = 1'b0;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (stat.range_empty) begin
          st_nxt = lvl2_r ? ST_NO_SECOND : ST_NO_FIRST;
          state_nxt = S_DONE;
        end else begin
          cmd.probe_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_done = 1'b1;
        fld_nxt = lvl2_r ? FLD_KEY2 : FLD_COUNT;
        state_nxt = S_FSTART;
      end
      S_FSTART: begin
        cmd.field_begin = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (stat.addr_bad) begin
          st_nxt = ST_OUT_OF_STORE;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_TAKE;
      S_TAKE: begin
        cmd.rd_take = 1'b1;
        if (!stat.field_last) state_nxt = S_RD;
        else begin
          case (fld_r)
            FLD_COUNT: begin fld_nxt = FLD_KEY1; state_nxt = S_FSTART; end
            FLD_KEY1:  begin fld_nxt = FLD_OFF1; state_nxt = S_FSTART; end
            FLD_KEY2:  begin fld_nxt = FLD_OFF2; state_nxt = S_FSTART; end
            default:   state_nxt = S_CMP;
          endcase
        end
      end
      S_CMP: begin
        if (lvl2_r) cmd.compare2 = 1'b1;
        else cmd.compare1 = 1'b1;
        if (stat.key_eq) begin
          if (lvl2_r) begin
            st_nxt = ST_FOUND;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
            lvl2_nxt = 1'b1;
            state_nxt = S_PROBE;
          end
        end else state_nxt = S_PROBE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // Second-level start: restart bounds from the hit entry's count.
    if (state_r == S_CMP && stat.key_eq && !lvl2_r) cmd.init_l2 = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      lvl2_r <= 1'b0;
      fld_r <= FLD_COUNT;
      st_r <= ST_WRITTEN;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      lvl2_r <= lvl2_nxt;
      fld_r <= fld_nxt;
      st_r <= st_nxt;
    end
  end

endmodule
